>>> rtl/srsp_pkg.sv
// srsp_pkg: shared widths, codes, reset values and structs for the speed ramp
// setpoint player. No dependencies; every rtl/srsp_* file and the core import it.
`timescale 1ns / 1ps

package srsp_pkg;

    // field widths
    localparam int SPEED_W     = 13;
    localparam int STEER_W     = 13;
    localparam int OUT_STEER_W = 14;
    localparam int BIAS_W      = 10;
    localparam int PERIOD_W    = 10;
    localparam int TIME_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    // speed differences need one bit more than a speed
    localparam int DIFF_W = SPEED_W + 1;

    // shared serial divider: dividend, divisor and step counter widths
    localparam int DIVD_W    = 16;
    localparam int DIVS_W    = 10;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

    // smallest speed change that still gets a ramp
    localparam int RAMP_MIN_CHANGE = 10;

    // operation codes
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // move status codes
    localparam logic [STATUS_W-1:0] ST_STOPPED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MOVING     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STEER_ONLY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEERING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEERING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_BIAS   = 3'd5;

    // configuration reset values
    localparam logic signed [SPEED_W-1:0] RST_MIN_SPEED    = 13'sd0;
    localparam logic signed [SPEED_W-1:0] RST_MAX_SPEED    = 13'sd1000;
    localparam logic signed [STEER_W-1:0] RST_MIN_STEERING = -13'sd1571;
    localparam logic signed [STEER_W-1:0] RST_MAX_STEERING = 13'sd1571;
    localparam logic [PERIOD_W-1:0]       RST_TICK_PERIOD  = 10'd20;
    localparam logic signed [BIAS_W-1:0]  RST_STEER_BIAS   = 10'sd0;

    typedef struct packed {
        logic signed [SPEED_W-1:0] min_speed;
        logic signed [SPEED_W-1:0] max_speed;
        logic signed [STEER_W-1:0] min_steering;
        logic signed [STEER_W-1:0] max_steering;
        logic [PERIOD_W-1:0]       tick_period_ms;
        logic signed [BIAS_W-1:0]  steering_bias;
    } srsp_cfg_t;

    // one classified item between front and back
    typedef struct packed {
        logic                      op;
        logic signed [SPEED_W-1:0] raw_speed;
        logic signed [SPEED_W-1:0] speed;
        logic signed [STEER_W-1:0] steering;
        logic                      smooth;
        logic [TIME_W-1:0]         smooth_time;
        logic [PERIOD_W-1:0]       period;
    } srsp_item_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } srsp_div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [DIVS_W-1:0] remainder;
    } srsp_div_resp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } srsp_fifo_stat_t;

    typedef struct packed {
        logic pop_cmd;
        logic pop_tick;
    } srsp_back_stat_t;

endpackage

>>> rtl/srsp_front.sv
// srsp_front: input side. Accepts beats, clamps speed, steering and ramp time,
// and pushes one classified item into the queue. Depends on srsp_pkg.
`timescale 1ns / 1ps

module srsp_front import srsp_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_operation,
    input  logic signed [SPEED_W-1:0] s_target_speed,
    input  logic signed [STEER_W-1:0] s_target_steering,
    input  logic                      s_smooth,
    input  logic [TIME_W-1:0]         s_smooth_time_ms,
    input  srsp_cfg_t                 cfg,
    input  srsp_fifo_stat_t           fifo_stat,
    output logic                      push,
    output srsp_item_t                push_item
);

    localparam int PMAX_W = PERIOD_W + $clog2(TABLE_DEPTH + 1);

    logic [PERIOD_W-1:0]       period;
    logic [PMAX_W-1:0]         period_ext;
    logic [PMAX_W-1:0]         period_max;
    logic [PMAX_W-1:0]         time_ext;
    logic [TIME_W-1:0]         time_clamped;
    logic signed [SPEED_W-1:0] speed_lo;
    logic signed [SPEED_W-1:0] speed_clamped;
    logic signed [STEER_W-1:0] steer_lo;
    logic signed [STEER_W-1:0] steer_clamped;

    // handshake: accept whenever the queue has room
    assign s_ready = !fifo_stat.full;
    assign push    = s_valid && !fifo_stat.full;

    // lower clamp first, upper clamp second, so the maximum wins
    always_comb begin
        speed_lo      = (s_target_speed < cfg.min_speed) ? cfg.min_speed : s_target_speed;
        speed_clamped = (speed_lo > cfg.max_speed) ? cfg.max_speed : speed_lo;
        steer_lo      = (s_target_steering < cfg.min_steering) ?
                        cfg.min_steering : s_target_steering;
        steer_clamped = (steer_lo > cfg.max_steering) ? cfg.max_steering : steer_lo;
    end

    // ramp time limited to one period up to one full table of periods
    always_comb begin
        period     = (cfg.tick_period_ms == '0) ? PERIOD_W'(1) : cfg.tick_period_ms;
        period_ext = PMAX_W'(period);
        period_max = period_ext * PMAX_W'(TABLE_DEPTH);
        time_ext   = PMAX_W'(s_smooth_time_ms);
        if (time_ext < period_ext) begin
            time_clamped = TIME_W'(period_ext);
        end else if (time_ext > period_max) begin
            time_clamped = TIME_W'(period_max);
        end else begin
            time_clamped = s_smooth_time_ms;
        end
    end

    always_comb begin
        push_item.op          = s_operation;
        push_item.raw_speed   = s_target_speed;
        push_item.speed       = speed_clamped;
        push_item.steering    = steer_clamped;
        push_item.smooth      = s_smooth;
        push_item.smooth_time = time_clamped;
        push_item.period      = period;
    end

endmodule

>>> rtl/srsp_fifo.sv
// srsp_fifo: two-entry queue of classified items between front and back.
// Depends on srsp_pkg for the item and status structs.
`timescale 1ns / 1ps

module srsp_fifo import srsp_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  srsp_item_t      push_item,
    input  logic            pop,
    output srsp_item_t      pop_item,
    output srsp_fifo_stat_t stat
);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    srsp_item_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_item   = entry_reg[rd_ptr_reg];

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/srsp_div.sv
// srsp_div: unsigned restoring divider, one quotient bit per cycle.
// Shared by the count and step divisions of a ramp. Depends on srsp_pkg.
`timescale 1ns / 1ps

module srsp_div import srsp_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  srsp_div_req_t  req,
    output srsp_div_resp_t resp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [DIVD_W-1:0]    quo_reg;
    logic [DIVS_W-1:0]    rem_reg;
    logic [DIVS_W-1:0]    divisor_reg;
    logic [DIVS_W:0]      shifted;
    logic [DIVS_W:0]      trial;

    // shift in the next dividend bit and try a subtract
    always_comb begin
        shifted = {rem_reg, quo_reg[DIVD_W-1]};
        trial   = shifted - {1'b0, divisor_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg    <= 1'b1;
                step_reg    <= '0;
                quo_reg     <= req.dividend;
                rem_reg     <= '0;
                divisor_reg <= req.divisor;
            end else if (busy_reg) begin
                if (!trial[DIVS_W]) begin
                    rem_reg <= trial[DIVS_W-1:0];
                    quo_reg <= {quo_reg[DIVD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted[DIVS_W-1:0];
                    quo_reg <= {quo_reg[DIVD_W-2:0], 1'b0};
                end
                step_reg <= step_reg + 1'b1;
                if (step_reg == DIV_CNT_W'(DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign resp.done      = done_reg;
    assign resp.quotient  = quo_reg;
    assign resp.remainder = rem_reg;

endmodule

>>> rtl/srsp_back.sv
// srsp_back: execution side. Fills the setpoint table for commands (ramp or
// flat) and plays it back on ticks into the result register.
// Depends on srsp_pkg; drives srsp_div through the request/response structs.
`timescale 1ns / 1ps

module srsp_back import srsp_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  srsp_cfg_t                     cfg,
    input  srsp_item_t                    head_item,
    input  srsp_fifo_stat_t               fifo_stat,
    output logic                          pop,
    output srsp_div_req_t                 div_req,
    input  srsp_div_resp_t                div_resp,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SPEED_W-1:0]     m_out_speed,
    output logic signed [OUT_STEER_W-1:0] m_out_steering,
    output logic [STATUS_W-1:0]           m_move_status,
    output srsp_back_stat_t               stat
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        B_IDLE,
        B_CNT_DIV,
        B_STEP_DIV,
        B_FILL,
        B_TICK
    } back_state_t;

    back_state_t               state_reg;
    logic signed [STEER_W-1:0] held_steer_reg;
    logic [IDX_W-1:0]          play_idx_reg;
    logic signed [SPEED_W-1:0] last_speed_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic signed [SPEED_W-1:0] target_reg;
    logic                      ramp_reg;
    logic                      neg_reg;
    logic [SPEED_W-1:0]        mag_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [SPEED_W-1:0]        step_q_reg;
    logic [DIVS_W-1:0]         step_r_reg;
    logic [SPEED_W-1:0]        acc_q_reg;
    logic [DIVS_W-1:0]         acc_r_reg;
    logic [IDX_W-1:0]          fill_idx_reg;
    logic                      div_start_reg;
    logic [DIVD_W-1:0]         div_dividend_reg;
    logic [DIVS_W-1:0]         div_divisor_reg;
    logic                      m_valid_reg;
    logic signed [SPEED_W-1:0] m_speed_reg;
    logic signed [OUT_STEER_W-1:0] m_steer_reg;
    logic [STATUS_W-1:0]       m_status_reg;

    logic [SPEED_W-1:0]        table_mem [TABLE_DEPTH];
    logic signed [SPEED_W-1:0] rd_data_reg;

    logic                      pop_cmd;
    logic                      pop_tick;
    logic signed [DIFF_W-1:0]  change;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_abs;
    logic                      ramp_hit;
    logic [CNT_W-1:0]          cnt_next;
    logic [DIVS_W:0]           r_sum;
    logic [DIVS_W:0]           cnt_ext;
    logic                      r_carry;
    logic [DIVS_W-1:0]         acc_r_next;
    logic [SPEED_W-1:0]        acc_q_next;
    logic signed [DIFF_W-1:0]  ramp_sum;
    logic                      wr_en;
    logic signed [SPEED_W-1:0] wr_data;
    logic signed [DIFF_W-1:0]  neg_steer;
    logic [STATUS_W-1:0]       status_next;

    // pop a command at once; a tick only when the result register is free
    always_comb begin
        pop      = (state_reg == B_IDLE) && !fifo_stat.empty &&
                   ((head_item.op == OP_COMMAND) || !m_valid_reg || m_ready);
        pop_cmd  = pop && (head_item.op == OP_COMMAND);
        pop_tick = pop && (head_item.op == OP_TICK);
    end

    assign stat.pop_cmd  = pop_cmd;
    assign stat.pop_tick = pop_tick;

    // ramp test on the unclamped target, ramp span on the clamped one
    always_comb begin
        change   = DIFF_W'(head_item.raw_speed) - DIFF_W'(last_speed_reg);
        diff     = DIFF_W'(head_item.speed) - DIFF_W'(last_speed_reg);
        diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        ramp_hit = head_item.smooth &&
                   ((change >= DIFF_W'(RAMP_MIN_CHANGE)) ||
                    (change <= -DIFF_W'(RAMP_MIN_CHANGE)));
    end

    // entry count from the first division, limited to 1..TABLE_DEPTH
    always_comb begin
        if (div_resp.quotient == '0) begin
            cnt_next = CNT_W'(1);
        end else if (div_resp.quotient > DIVD_W'(TABLE_DEPTH)) begin
            cnt_next = CNT_W'(TABLE_DEPTH);
        end else begin
            cnt_next = div_resp.quotient[CNT_W-1:0];
        end
    end

    // running quotient of |diff|*(i+1)/cnt: add step, carry the remainder once
    always_comb begin
        cnt_ext    = (DIVS_W + 1)'(cnt_reg);
        r_sum      = {1'b0, acc_r_reg} + {1'b0, step_r_reg};
        r_carry    = (r_sum >= cnt_ext);
        acc_r_next = r_carry ? DIVS_W'(r_sum - cnt_ext) : r_sum[DIVS_W-1:0];
        acc_q_next = acc_q_reg + step_q_reg + SPEED_W'(r_carry);
    end

    // table write data: ramp entry below the count, target at and above it
    always_comb begin
        ramp_sum = neg_reg ?
                   (DIFF_W'(last_speed_reg) - $signed({1'b0, acc_q_reg})) :
                   (DIFF_W'(last_speed_reg) + $signed({1'b0, acc_q_reg}));
        wr_en    = (state_reg == B_FILL);
        wr_data  = (ramp_reg && (CNT_W'(fill_idx_reg) < cnt_reg)) ?
                   ramp_sum[SPEED_W-1:0] : target_reg;
    end

    // move status, judged before the bias; held when moving straight
    always_comb begin
        neg_steer = -DIFF_W'(held_steer_reg);
        if ((rd_data_reg == '0) && (neg_steer == '0)) begin
            status_next = ST_STOPPED;
        end else if ((rd_data_reg != '0) && (neg_steer != '0)) begin
            status_next = ST_MOVING;
        end else if (rd_data_reg == '0) begin
            status_next = ST_STEER_ONLY;
        end else begin
            status_next = status_reg;
        end
    end

    // setpoint table: one write port for fills, registered read for ticks
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[fill_idx_reg] <= wr_data;
        end
        if (pop_tick) begin
            rd_data_reg <= table_mem[play_idx_reg];
        end
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_IDLE;
            held_steer_reg <= '0;
            play_idx_reg   <= IDX_W'(TABLE_DEPTH - 1);
            last_speed_reg <= '0;
            status_reg     <= ST_STOPPED;
            div_start_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (pop_cmd) begin
                        held_steer_reg <= head_item.steering;
                        target_reg     <= head_item.speed;
                        ramp_reg       <= ramp_hit;
                        neg_reg        <= diff[DIFF_W-1];
                        mag_reg        <= diff_abs[SPEED_W-1:0];
                        fill_idx_reg   <= '0;
                        if (ramp_hit) begin
                            play_idx_reg     <= '0;
                            div_start_reg    <= 1'b1;
                            div_dividend_reg <= DIVD_W'(head_item.smooth_time);
                            div_divisor_reg  <= DIVS_W'(head_item.period);
                            state_reg        <= B_CNT_DIV;
                        end else begin
                            play_idx_reg <= IDX_W'(TABLE_DEPTH - 1);
                            state_reg    <= B_FILL;
                        end
                    end else if (pop_tick) begin
                        state_reg <= B_TICK;
                    end
                end
                B_CNT_DIV: begin
                    if (div_resp.done) begin
                        cnt_reg          <= cnt_next;
                        div_start_reg    <= 1'b1;
                        div_dividend_reg <= DIVD_W'(mag_reg);
                        div_divisor_reg  <= DIVS_W'(cnt_next);
                        state_reg        <= B_STEP_DIV;
                    end
                end
                B_STEP_DIV: begin
                    if (div_resp.done) begin
                        step_q_reg <= div_resp.quotient[SPEED_W-1:0];
                        step_r_reg <= div_resp.remainder;
                        acc_q_reg  <= div_resp.quotient[SPEED_W-1:0];
                        acc_r_reg  <= div_resp.remainder;
                        state_reg  <= B_FILL;
                    end
                end
                B_FILL: begin
                    acc_q_reg    <= acc_q_next;
                    acc_r_reg    <= acc_r_next;
                    fill_idx_reg <= fill_idx_reg + 1'b1;
                    if (fill_idx_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                        fill_idx_reg <= '0;
                        state_reg    <= B_IDLE;
                    end
                end
                B_TICK: begin
                    m_valid_reg    <= 1'b1;
                    m_speed_reg    <= rd_data_reg;
                    m_steer_reg    <= neg_steer + OUT_STEER_W'(cfg.steering_bias);
                    m_status_reg   <= status_next;
                    status_reg     <= status_next;
                    last_speed_reg <= rd_data_reg;
                    if (play_idx_reg != IDX_W'(TABLE_DEPTH - 1)) begin
                        play_idx_reg <= play_idx_reg + 1'b1;
                    end
                    state_reg <= B_IDLE;
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_dividend_reg;
    assign div_req.divisor  = div_divisor_reg;

    assign m_valid        = m_valid_reg;
    assign m_out_speed    = m_speed_reg;
    assign m_out_steering = m_steer_reg;
    assign m_move_status  = m_status_reg;

endmodule

>>> rtl/speed_ramp_setpoint_player_core.sv
// speed_ramp_setpoint_player_core: top level. Holds the configuration registers
// and ties front, queue, divider and back together. Depends on srsp_pkg and all
// rtl/srsp_* modules.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------
//  s_       | in        | s_valid / s_ready  | operation, target speed/steering, ramp
//  m_       | out       | m_valid / m_ready  | out_speed, out_steering, move_status
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A tick goes from the queue head through the registered table read into the result register.
// A flat command writes the table one entry per cycle. A ramp command first runs
// two divisions in the shared serial divider, entry count then step size, before
// its fill. The two-entry queue keeps taking beats while it is not full, also
// while the back end fills or the result waits.
// Reset is synchronous and active low; the table holds no data until the first command.
`timescale 1ns / 1ps

module speed_ramp_setpoint_player_core import srsp_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic signed [SPEED_W-1:0]     s_target_speed,
    input  logic signed [STEER_W-1:0]     s_target_steering,
    input  logic                          s_smooth,
    input  logic [TIME_W-1:0]             s_smooth_time_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SPEED_W-1:0]     m_out_speed,
    output logic signed [OUT_STEER_W-1:0] m_out_steering,
    output logic [STATUS_W-1:0]           m_move_status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    srsp_cfg_t       cfg_reg;
    srsp_fifo_stat_t fifo_stat;
    srsp_item_t      push_item;
    srsp_item_t      head_item;
    srsp_div_req_t   div_req;
    srsp_div_resp_t  div_resp;
    srsp_back_stat_t back_stat;
    logic            push;
    logic            pop;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_speed      <= RST_MIN_SPEED;
            cfg_reg.max_speed      <= RST_MAX_SPEED;
            cfg_reg.min_steering   <= RST_MIN_STEERING;
            cfg_reg.max_steering   <= RST_MAX_STEERING;
            cfg_reg.tick_period_ms <= RST_TICK_PERIOD;
            cfg_reg.steering_bias  <= RST_STEER_BIAS;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_SPEED:    cfg_reg.min_speed      <= cfg_data;
                CFG_MAX_SPEED:    cfg_reg.max_speed      <= cfg_data;
                CFG_MIN_STEERING: cfg_reg.min_steering   <= cfg_data;
                CFG_MAX_STEERING: cfg_reg.max_steering   <= cfg_data;
                CFG_TICK_PERIOD:  cfg_reg.tick_period_ms <= cfg_data[PERIOD_W-1:0];
                CFG_STEER_BIAS:   cfg_reg.steering_bias  <= cfg_data[BIAS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    srsp_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_target_speed    (s_target_speed),
        .s_target_steering (s_target_steering),
        .s_smooth          (s_smooth),
        .s_smooth_time_ms  (s_smooth_time_ms),
        .cfg               (cfg_reg),
        .fifo_stat         (fifo_stat),
        .push              (push),
        .push_item         (push_item)
    );

    srsp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (head_item),
        .stat      (fifo_stat)
    );

    srsp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    srsp_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .head_item      (head_item),
        .fifo_stat      (fifo_stat),
        .pop            (pop),
        .div_req        (div_req),
        .div_resp       (div_resp),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_speed    (m_out_speed),
        .m_out_steering (m_out_steering),
        .m_move_status  (m_move_status),
        .stat           (back_stat)
    );

    // queue level is never full and empty at once
    a_fifo_level: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("queue reports full and empty together");

    // an accepted beat is in the queue on the next cycle
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !fifo_stat.empty)
        else $error("accepted beat missing from queue");

    // a rising result valid only follows a tick taken from the queue, via the table read
    a_result_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(back_stat.pop_tick, 2))
        else $error("result appeared without a tick");

    // the back end takes one item per pop
    a_single_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(back_stat.pop_cmd && back_stat.pop_tick))
        else $error("command and tick popped together");

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking bench for speed_ramp_setpoint_player_core. A directed table, then
// random command/tick bursts over several register settings, scored against a local model.
// Depends on srsp_pkg and the rtl/ sources of the core.
`timescale 1ns / 1ps

module tb_top;
    import srsp_pkg::*;

    localparam int TABLE_DEPTH     = 64;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 300;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int NUM_PHASES      = 9;
    localparam int HOLD_CYCLES     = 500;

    // one emitted setpoint
    typedef struct packed {
        logic signed [SPEED_W-1:0]     speed;
        logic signed [OUT_STEER_W-1:0] steer;
        logic [STATUS_W-1:0]           status;
    } setpoint_t;

    // one input beat, with an optional hand-typed setpoint for ticks
    typedef struct packed {
        logic                      op;
        logic signed [SPEED_W-1:0] spd;
        logic signed [STEER_W-1:0] str;
        logic                      sm;
        logic [TIME_W-1:0]         tm;
        logic                      typed;
        setpoint_t                 expected;
    } stim_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_operation = OP_COMMAND;
    logic signed [SPEED_W-1:0]     s_target_speed = '0;
    logic signed [STEER_W-1:0]     s_target_steering = '0;
    logic                          s_smooth = 1'b0;
    logic [TIME_W-1:0]             s_smooth_time_ms = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [SPEED_W-1:0]     m_out_speed;
    logic signed [OUT_STEER_W-1:0] m_out_steering;
    logic [STATUS_W-1:0]           m_move_status;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    // model copy of configuration
    logic signed [SPEED_W-1:0]  cfg_min_spd = RST_MIN_SPEED;
    logic signed [SPEED_W-1:0]  cfg_max_spd = RST_MAX_SPEED;
    logic signed [STEER_W-1:0]  cfg_min_str = RST_MIN_STEERING;
    logic signed [STEER_W-1:0]  cfg_max_str = RST_MAX_STEERING;
    logic [PERIOD_W-1:0]        cfg_period  = RST_TICK_PERIOD;
    logic signed [BIAS_W-1:0]   cfg_bias    = RST_STEER_BIAS;

    // model copy of player state
    logic signed [SPEED_W-1:0]  speed_tbl [TABLE_DEPTH];
    logic signed [STEER_W-1:0]  held_steer = '0;
    int                         play_ptr = TABLE_DEPTH - 1;
    logic signed [SPEED_W-1:0]  last_spd = '0;
    logic [STATUS_W-1:0]        status_now = ST_STOPPED;

    setpoint_t setpoint_q [$];
    stim_row_t directed_rows [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        s_idle_pct = 0;
    int        m_idle_pct = 0;
    bit        hold_req = 1'b0;

    speed_ramp_setpoint_player_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_target_speed    (s_target_speed),
        .s_target_steering (s_target_steering),
        .s_smooth          (s_smooth),
        .s_smooth_time_ms  (s_smooth_time_ms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_speed       (m_out_speed),
        .m_out_steering    (m_out_steering),
        .m_move_status     (m_move_status),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int limit_to(input int v, input int lo, input int hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    // command: clamp, then fill the table with a ramp or a flat target
    function automatic void load_command(input stim_row_t r);
        int  raw, v, d, change, period, st, cnt, diff, i;
        bit  ramp;
        raw    = int'(r.spd);
        v      = limit_to(raw, int'(cfg_min_spd), int'(cfg_max_spd));
        d      = limit_to(int'(r.str), int'(cfg_min_str), int'(cfg_max_str));
        change = raw - int'(last_spd);
        ramp   = r.sm && (change >= RAMP_MIN_CHANGE || change <= -RAMP_MIN_CHANGE);
        held_steer = STEER_W'(d);
        if (ramp) begin
            period = (cfg_period == 0) ? 1 : int'(cfg_period);
            st = int'(r.tm);
            if (st < period) st = period;
            if (st > period * TABLE_DEPTH) st = period * TABLE_DEPTH;
            cnt = limit_to(st / period, 1, TABLE_DEPTH);
            diff = v - int'(last_spd);
            for (i = 0; i < TABLE_DEPTH; i++) begin
                if (i < cnt)
                    speed_tbl[i] = SPEED_W'(int'(last_spd) + (diff * (i + 1)) / cnt);
                else
                    speed_tbl[i] = SPEED_W'(v);
            end
            play_ptr = 0;
        end else begin
            for (i = 0; i < TABLE_DEPTH; i++) speed_tbl[i] = SPEED_W'(v);
            play_ptr = TABLE_DEPTH - 1;
        end
    endfunction

    // tick: emit current entry, update status, advance saturating pointer
    function automatic setpoint_t play_tick();
        setpoint_t sp_out;
        int        sp, ns;
        sp = int'(speed_tbl[play_ptr]);
        ns = -int'(held_steer);
        if (sp == 0 && ns == 0)
            status_now = ST_STOPPED;
        else if (sp != 0 && ns != 0)
            status_now = ST_MOVING;
        else if (sp == 0)
            status_now = ST_STEER_ONLY;
        // moving with zero steering keeps the old status
        sp_out.speed  = SPEED_W'(sp);
        sp_out.steer  = OUT_STEER_W'(ns + int'(cfg_bias));
        sp_out.status = status_now;
        last_spd = SPEED_W'(sp);
        if (play_ptr < TABLE_DEPTH - 1) play_ptr++;
        return sp_out;
    endfunction

    task automatic add_row(input logic op, input int spd, input int str, input logic sm,
                           input int tm, input logic typed, input int e_spd, input int e_str,
                           input logic [STATUS_W-1:0] e_st);
        stim_row_t r;
        r.op              = op;
        r.spd             = SPEED_W'(spd);
        r.str             = STEER_W'(str);
        r.sm              = sm;
        r.tm              = TIME_W'(tm);
        r.typed           = typed;
        r.expected.speed  = SPEED_W'(e_spd);
        r.expected.steer  = OUT_STEER_W'(e_str);
        r.expected.status = e_st;
        directed_rows.push_back(r);
    endtask

    function automatic stim_row_t random_tick();
        stim_row_t r;
        r.op       = OP_TICK;
        r.spd      = SPEED_W'($urandom);
        r.str      = STEER_W'($urandom);
        r.sm       = 1'($urandom);
        r.tm       = TIME_W'($urandom);
        r.typed    = 1'b0;
        r.expected = '0;
        return r;
    endfunction

    function automatic stim_row_t random_command();
        stim_row_t r;
        int        pick, near, period;
        r.op   = OP_COMMAND;
        pick   = int'($urandom_range(0, 9));
        period = (cfg_period == 0) ? 1 : int'(cfg_period);
        if (pick < 4 && cfg_min_spd <= cfg_max_spd) begin
            r.spd = SPEED_W'(int'(cfg_min_spd) +
                             int'($urandom_range(0, int'(cfg_max_spd) - int'(cfg_min_spd))));
        end else if (pick < 6) begin
            // straddle the ramp threshold around the last emitted speed
            near  = int'(last_spd) + int'($urandom_range(0, 30)) - 15;
            r.spd = SPEED_W'(limit_to(near, -4096, 4095));
        end else begin
            r.spd = SPEED_W'($urandom);
        end
        r.str = ($urandom_range(0, 4) == 0) ? '0 : STEER_W'($urandom);
        r.sm  = ($urandom_range(0, 9) < 7);
        case ($urandom_range(0, 4))
            0:       r.tm = TIME_W'(period * int'($urandom_range(0, 70)));
            1:       r.tm = TIME_W'($urandom_range(0, 50));
            default: r.tm = TIME_W'($urandom);
        endcase
        r.typed    = 1'b0;
        r.expected = '0;
        return r;
    endfunction

    // drive one input beat, predict on acceptance
    task automatic send_row(input stim_row_t r);
        setpoint_t sp;
        while ($urandom_range(99) < s_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_valid           <= 1'b1;
        s_operation       <= r.op;
        s_target_speed    <= r.spd;
        s_target_steering <= r.str;
        s_smooth          <= r.sm;
        s_smooth_time_ms  <= r.tm;
        do @(posedge aclk); while (!s_ready);
        if (r.op == OP_COMMAND) begin
            load_command(r);
        end else begin
            sp = play_tick();
            if (r.typed) sp = r.expected;
            setpoint_q.push_back(sp);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MIN_SPEED:    cfg_min_spd = data[SPEED_W-1:0];
            CFG_MAX_SPEED:    cfg_max_spd = data[SPEED_W-1:0];
            CFG_MIN_STEERING: cfg_min_str = data[STEER_W-1:0];
            CFG_MAX_STEERING: cfg_max_str = data[STEER_W-1:0];
            CFG_TICK_PERIOD:  cfg_period  = data[PERIOD_W-1:0];
            CFG_STEER_BIAS:   cfg_bias    = data[BIAS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int min_s, input int max_s, input int min_d,
                             input int max_d, input int period, input int bias);
        write_reg(CFG_MIN_SPEED, min_s);
        write_reg(CFG_MAX_SPEED, max_s);
        write_reg(CFG_MIN_STEERING, min_d);
        write_reg(CFG_MAX_STEERING, max_d);
        write_reg(CFG_TICK_PERIOD, period);
        write_reg(CFG_STEER_BIAS, bias);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering, wait for every setpoint, then let a pending table fill finish
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (setpoint_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_setpoint();
        setpoint_t want;
        if (setpoint_q.size() == 0) begin
            $display("%0t: unexpected setpoint speed %0d steering %0d status %0d",
                     $time, m_out_speed, m_out_steering, m_move_status);
            mismatch_count++;
        end else begin
            want = setpoint_q.pop_front();
            if (m_out_speed !== want.speed) begin
                $display("%0t: out_speed expected %0d actual %0d",
                         $time, want.speed, m_out_speed);
                mismatch_count++;
            end
            if (m_out_steering !== want.steer) begin
                $display("%0t: out_steering expected %0d actual %0d",
                         $time, want.steer, m_out_steering);
                mismatch_count++;
            end
            if (m_move_status !== want.status) begin
                $display("%0t: move_status expected %0d actual %0d",
                         $time, want.status, m_move_status);
                mismatch_count++;
            end
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= m_idle_pct);
            end
            @(posedge aclk);
            if (m_valid && m_ready) check_setpoint();
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d setpoints outstanding",
                 $time, cycle_count, setpoint_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int phase, n, burst, k;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, reset limits: speed 0..1000, steering +-1571, 20 ms, no bias
        add_row(OP_COMMAND, 0, 0, 1'b0, 0, 1'b0, 0, 0, ST_STOPPED);
        add_row(OP_TICK, 0, 0, 1'b0, 0, 1'b1, 0, 0, ST_STOPPED);
        add_row(OP_COMMAND, 4095, 4095, 1'b0, 65535, 1'b0, 0, 0, ST_STOPPED);
        add_row(OP_TICK, 0, 0, 1'b0, 0, 1'b1, 1000, -1571, ST_MOVING);
        add_row(OP_COMMAND, -4096, -4096, 1'b0, 0, 1'b0, 0, 0, ST_STOPPED);
        add_row(OP_TICK, 0, 0, 1'b0, 0, 1'b1, 0, 1571, ST_STEER_ONLY);
        // moving straight: status is held from the previous tick
        add_row(OP_COMMAND, 500, 0, 1'b0, 0, 1'b0, 0, 0, ST_STOPPED);
        add_row(OP_TICK, 0, 0, 1'b0, 0, 1'b1, 500, 0, ST_STEER_ONLY);
        // five-step ramp, played past its end
        add_row(OP_COMMAND, 1000, 100, 1'b1, 100, 1'b0, 0, 0, ST_STOPPED);
        for (k = 0; k < 6; k++) add_row(OP_TICK, 0, 0, 1'b0, 0, 1'b0, 0, 0, ST_STOPPED);
        // change below threshold: flat fill even with smoothing asked
        add_row(OP_COMMAND, 1005, 0, 1'b1, 40, 1'b0, 0, 0, ST_STOPPED);
        add_row(OP_TICK, 0, 0, 1'b0, 0, 1'b0, 0, 0, ST_STOPPED);
        // zero duration raised to one period
        add_row(OP_COMMAND, -4096, -4096, 1'b1, 0, 1'b0, 0, 0, ST_STOPPED);
        add_row(OP_TICK, 0, 0, 1'b0, 0, 1'b0, 0, 0, ST_STOPPED);
        // longest duration cut to a full table
        add_row(OP_COMMAND, 1000, 4095, 1'b1, 65535, 1'b0, 0, 0, ST_STOPPED);
        add_row(OP_TICK, 0, 0, 1'b0, 0, 1'b0, 0, 0, ST_STOPPED);
        add_row(OP_TICK, 0, 0, 1'b0, 0, 1'b0, 0, 0, ST_STOPPED);

        s_idle_pct = 23;
        m_idle_pct = 65;
        foreach (directed_rows[k]) send_row(directed_rows[k]);

        // random part over several register settings
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            case (phase)
                0: configure(-1000, 1000, -1571, 1571, 20, 0);
                1: configure(-4096, 4095, -4096, 4095, 1, -512);
                2: configure(0, 1000, -1571, 1571, 1000, 511);
                3: configure(200, -200, 300, -300, 0, 100);     // inverted limits, zero period
                4: configure(-4096, 4095, -4096, 4095, 7, 511);
                5: configure(-500, 3000, -2000, 100, 1000, -512);
                6: configure(-4096, 4095, -4096, 4095, 33, -1);
                7: configure(4095, 4095, -4096, -4096, 3, 0);
                default: configure(-4096, 4095, -4096, 4095, 64, 255);
            endcase
            if (phase < 3) begin
                s_idle_pct = 23;
                m_idle_pct = 65;
            end else if (phase < 6) begin
                s_idle_pct = 65;
                m_idle_pct = 23;
            end else begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            if (phase == 6) hold_req = 1'b1;
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                send_row(random_command());
                n++;
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9: burst = int'($urandom_range(0, 6));
                    17, 18, 19:                   burst = int'($urandom_range(60, 70));
                    default:                      burst = int'($urandom_range(7, 20));
                endcase
                repeat (burst) begin
                    send_row(random_tick());
                    n++;
                end
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
